@@ sv/ffha_pkg.sv @@
// Shared types and constants for the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;

  localparam int OP_W     = 2;
  localparam int SIZE_W   = 21;
  localparam int HANDLE_W = 20;
  localparam int ADDR_W   = 20;
  localparam int END_W    = 21;
  localparam int LIMIT_W  = 21;
  // internal byte-offset width: holds a block end plus a rounded size
  localparam int VW       = 23;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'd1048576;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_RESIZE = 2'd1,
    OP_FREE   = 2'd2,
    OP_BAD    = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_RD_IDX,
    CMD_RD_NX,
    CMD_RD_PV,
    CMD_RD_ZERO,
    CMD_FIND_STEP,
    CMD_RSZ_COMMIT,
    CMD_CLEAR,
    CMD_SET_FE,
    CMD_FREE_TRIM,
    CMD_FREE_LINK1,
    CMD_FREE_LINK2,
    CMD_ALLOC_FIRST,
    CMD_WALK_INIT,
    CMD_WALK_END,
    CMD_WALK_STEP,
    CMD_REUSE0,
    CMD_SCAN_INIT,
    CMD_IDX_INC,
    CMD_NEW_BLOCK,
    CMD_LINK_PREV,
    CMD_LINK_NEXT,
    CMD_LOAD_OUT
  } dp_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_RSZ_RD,
    ST_RSZ_CHK,
    ST_FREE_DEC,
    ST_FREE_TRIM,
    ST_FREE_LINK2,
    ST_ALLOC_START,
    ST_ALLOC_INIT,
    ST_WALK,
    ST_WALK_NXT,
    ST_PLACE,
    ST_SCAN,
    ST_NEW,
    ST_LINK_PREV,
    ST_LINK_NEXT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    op_t  op;
    logic match;
    logic idx_last;
    logic idx_free;
    logic size_zero;
    logic busy0;
    logic sz_over_lim;
    logic nx_valid;
    logic pv_valid;
    logic cur_zero;
    logic pv_zero;
    logic fe;
    logic n_full;
    logic tend_over_top;
    logic tend_over_lim;
    logic fits;
    logic rsz_over_top;
    logic rsz_over_lim;
    logic rsz_collide;
  } dp_status_t;

endpackage

@@ sv/ffha_ctrl.sv @@
// Sequencer for the heap allocator: walks lists and issues datapath commands.
`timescale 1ns / 1ps
module ffha_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ffha_pkg::dp_status_t st,
  output ffha_pkg::dp_cmd_t   cmd
);
  import ffha_pkg::*;

  state_t state, state_next;
  logic   out_load;

  assign in_ready = (state == ST_IDLE);
  assign out_load = (state == ST_FINISH) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        case (st.op)
          OP_ALLOC:  state_next = ST_ALLOC_START;
          OP_RESIZE: state_next = ST_FIND_RD;
          OP_FREE:   state_next = ST_FIND_RD;
          default:   state_next = ST_FINISH;
        endcase
      end
      ST_FIND_RD:  state_next = ST_FIND_CHK;
      ST_FIND_CHK: begin
        if (st.match) state_next = (st.op == OP_RESIZE) ? ST_RSZ_RD : ST_FREE_DEC;
        else if (st.idx_last) state_next = ST_FINISH;
        else state_next = ST_FIND_RD;
      end
      ST_RSZ_RD:   state_next = ST_RSZ_CHK;
      ST_RSZ_CHK:  state_next = ST_FINISH;
      ST_FREE_DEC: begin
        if (st.cur_zero || !st.pv_valid) state_next = ST_FINISH;
        else if (!st.nx_valid) state_next = (st.pv_zero && st.fe) ? ST_FINISH : ST_FREE_TRIM;
        else state_next = ST_FREE_LINK2;
      end
      ST_FREE_TRIM:   state_next = ST_FINISH;
      ST_FREE_LINK2:  state_next = ST_FINISH;
      ST_ALLOC_START: begin
        if (st.size_zero || !st.busy0) state_next = ST_FINISH;
        else state_next = ST_ALLOC_INIT;
      end
      ST_ALLOC_INIT: state_next = ST_WALK;
      ST_WALK: begin
        if (st.n_full) state_next = ST_FINISH;
        else if (!st.nx_valid)
          state_next = (st.tend_over_top && st.tend_over_lim) ? ST_FINISH : ST_PLACE;
        else state_next = ST_WALK_NXT;
      end
      ST_WALK_NXT: state_next = st.fits ? ST_PLACE : ST_WALK;
      ST_PLACE:    state_next = (st.cur_zero && st.fe) ? ST_FINISH : ST_SCAN;
      ST_SCAN: begin
        if (st.idx_free) state_next = ST_NEW;
        else if (st.idx_last) state_next = ST_FINISH;
      end
      ST_NEW:       state_next = st.nx_valid ? ST_LINK_PREV : ST_LINK_NEXT;
      ST_LINK_PREV: state_next = ST_LINK_NEXT;
      ST_LINK_NEXT: state_next = ST_FINISH;
      ST_FINISH:    if (out_load) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = CMD_NONE;
    case (state)
      ST_IDLE:     if (in_valid) cmd = CMD_LATCH;
      ST_FIND_RD:  cmd = CMD_RD_IDX;
      ST_FIND_CHK: cmd = CMD_FIND_STEP;
      ST_RSZ_RD:   cmd = CMD_RD_NX;
      ST_RSZ_CHK: begin
        if (st.nx_valid) begin
          if (!st.rsz_collide) cmd = CMD_RSZ_COMMIT;
        end else if (!(st.rsz_over_top && st.rsz_over_lim)) begin
          cmd = CMD_RSZ_COMMIT;
        end
      end
      ST_FREE_DEC: begin
        if (st.cur_zero) cmd = st.nx_valid ? CMD_SET_FE : CMD_CLEAR;
        else if (st.pv_valid) begin
          if (st.nx_valid) cmd = CMD_FREE_LINK1;
          else cmd = (st.pv_zero && st.fe) ? CMD_CLEAR : CMD_RD_PV;
        end
      end
      ST_FREE_TRIM:  cmd = CMD_FREE_TRIM;
      ST_FREE_LINK2: cmd = CMD_FREE_LINK2;
      ST_ALLOC_START: begin
        if (!st.size_zero) begin
          if (st.busy0) cmd = CMD_RD_ZERO;
          else if (!st.sz_over_lim) cmd = CMD_ALLOC_FIRST;
        end
      end
      ST_ALLOC_INIT: cmd = CMD_WALK_INIT;
      ST_WALK: begin
        if (!st.n_full) begin
          if (st.nx_valid) cmd = CMD_RD_NX;
          else if (!(st.tend_over_top && st.tend_over_lim)) cmd = CMD_WALK_END;
        end
      end
      ST_WALK_NXT:  if (!st.fits) cmd = CMD_WALK_STEP;
      ST_PLACE:     cmd = (st.cur_zero && st.fe) ? CMD_REUSE0 : CMD_SCAN_INIT;
      ST_SCAN:      if (!st.idx_free && !st.idx_last) cmd = CMD_IDX_INC;
      ST_NEW:       cmd = CMD_NEW_BLOCK;
      ST_LINK_PREV: cmd = CMD_LINK_PREV;
      ST_LINK_NEXT: cmd = CMD_LINK_NEXT;
      ST_FINISH:    if (out_load) cmd = CMD_LOAD_OUT;
      default:      cmd = CMD_NONE;
    endcase
  end

endmodule

@@ sv/ffha_dp.sv @@
// Datapath: block table memories, busy bits, heap top, limit and result register.
`timescale 1ns / 1ps
module ffha_dp #(
  parameter int MAX_BLOCKS        = 64,
  parameter int HEAP_ADDR_BITS    = 20,
  parameter int ALIGN_BITS        = 3,
  parameter int HEADER_BYTES      = 24,
  parameter int RELEASE_THRESHOLD = 32768
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ffha_pkg::dp_cmd_t               cmd,
  output ffha_pkg::dp_status_t            st,
  input  logic [ffha_pkg::OP_W-1:0]       in_op,
  input  logic [ffha_pkg::SIZE_W-1:0]     in_size,
  input  logic [ffha_pkg::HANDLE_W-1:0]   in_handle,
  input  logic                            cfg_we,
  input  logic [ffha_pkg::LIMIT_W-1:0]    cfg_limit,
  output logic                            out_ok,
  output logic [ffha_pkg::ADDR_W-1:0]     out_addr,
  output logic [ffha_pkg::END_W-1:0]      out_end
);
  import ffha_pkg::*;

  localparam int SW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int LW = $clog2(MAX_BLOCKS + 1);
  localparam logic [LW-1:0] NIL     = LW'(MAX_BLOCKS);
  localparam logic [SW-1:0] IDX_TOP = SW'(MAX_BLOCKS - 1);
  localparam logic [VW-1:0] HDR     = VW'(HEADER_BYTES);
  localparam logic [VW-1:0] AMASK   = VW'((1 << ALIGN_BITS) - 1);
  localparam logic [VW-1:0] THR     = VW'(RELEASE_THRESHOLD);
  localparam logic [VW-1:0] SPAN    = (HEAP_ADDR_BITS >= VW - 1) ?
                                      (VW'(1) << (VW - 1)) : (VW'(1) << HEAP_ADDR_BITS);
  localparam logic [MAX_BLOCKS-1:0] ONLY0 = MAX_BLOCKS'(1);

  // block table
  logic [VW-1:0] mem_start [MAX_BLOCKS];
  logic [VW-1:0] mem_end   [MAX_BLOCKS];
  logic [LW-1:0] mem_next  [MAX_BLOCKS];
  logic [LW-1:0] mem_prev  [MAX_BLOCKS];
  logic [VW-1:0] rd_start, rd_end;
  logic [LW-1:0] rd_next, rd_prev;

  logic [SW-1:0] rd_addr, wr_addr;
  logic          we_start, we_end, we_next, we_prev;
  logic [VW-1:0] w_start, w_end;
  logic [LW-1:0] w_next, w_prev;

  logic [MAX_BLOCKS-1:0] busy;
  logic [VW-1:0]         top;
  logic                  fe;
  logic [LIMIT_W-1:0]    limit;

  op_t                 op;
  logic [SIZE_W-1:0]   size;
  logic [HANDLE_W-1:0] handle;
  logic [SW-1:0]       idx, cur;
  logic [LW-1:0]       nx, pv, n;
  logic [VW-1:0]       t_end, cur_end, new_top;
  logic                ok;
  logic [ADDR_W-1:0]   addr;

  logic [VW-1:0] lim, sz, rsz_end;
  logic          nx_valid, pv_valid;

  assign lim     = ({2'b0, limit} < SPAN) ? {2'b0, limit} : SPAN;
  assign sz      = ({2'b0, size} + HDR + AMASK) & ~AMASK;
  assign rsz_end = {3'b0, handle} + (({2'b0, size} + AMASK) & ~AMASK);
  assign nx_valid = (nx < NIL) && busy[nx[SW-1:0]];
  assign pv_valid = (pv < NIL) && busy[pv[SW-1:0]];

  always_comb begin
    st.op            = op;
    st.match         = busy[idx] && !(idx == '0 && fe) &&
                       ((rd_start + HDR) == {3'b0, handle});
    st.idx_last      = (idx == IDX_TOP);
    st.idx_free      = !busy[idx];
    st.size_zero     = (size == '0);
    st.busy0         = busy[0];
    st.sz_over_lim   = (sz > lim);
    st.nx_valid      = nx_valid;
    st.pv_valid      = pv_valid;
    st.cur_zero      = (cur == '0);
    st.pv_zero       = (pv == '0);
    st.fe            = fe;
    st.n_full        = (n == NIL);
    st.tend_over_top = (t_end > top);
    st.tend_over_lim = (t_end > lim);
    st.fits          = (rd_start >= t_end);
    st.rsz_over_top  = (rsz_end > top);
    st.rsz_over_lim  = (rsz_end > lim);
    st.rsz_collide   = (rd_start < rsz_end);
  end

  always_comb begin
    rd_addr = '0;
    case (cmd)
      CMD_RD_IDX: rd_addr = idx;
      CMD_RD_NX:  rd_addr = nx[SW-1:0];
      CMD_RD_PV:  rd_addr = pv[SW-1:0];
      default:    rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_addr  = '0;
    we_start = 1'b0;
    we_end   = 1'b0;
    we_next  = 1'b0;
    we_prev  = 1'b0;
    w_start  = cur_end;
    w_end    = t_end;
    w_next   = NIL;
    w_prev   = NIL;
    case (cmd)
      CMD_ALLOC_FIRST: begin
        {we_start, we_end, we_next, we_prev} = 4'b1111;
        w_start = '0;
        w_end   = sz;
      end
      CMD_RSZ_COMMIT: begin
        wr_addr = cur;
        we_end  = 1'b1;
        w_end   = rsz_end;
      end
      CMD_REUSE0: we_end = 1'b1;
      CMD_NEW_BLOCK: begin
        wr_addr = idx;
        {we_start, we_end, we_next, we_prev} = 4'b1111;
        w_prev  = LW'(cur);
        w_next  = nx_valid ? nx : NIL;
      end
      CMD_LINK_PREV: begin
        wr_addr = nx[SW-1:0];
        we_prev = 1'b1;
        w_prev  = LW'(idx);
      end
      CMD_LINK_NEXT: begin
        wr_addr = cur;
        we_next = 1'b1;
        w_next  = LW'(idx);
      end
      CMD_FREE_TRIM: begin
        wr_addr = pv[SW-1:0];
        we_next = 1'b1;
      end
      CMD_FREE_LINK1: begin
        wr_addr = pv[SW-1:0];
        we_next = 1'b1;
        w_next  = nx;
      end
      CMD_FREE_LINK2: begin
        wr_addr = nx[SW-1:0];
        we_prev = 1'b1;
        w_prev  = pv;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_start) mem_start[wr_addr] <= w_start;
    if (we_end)   mem_end[wr_addr]   <= w_end;
    if (we_next)  mem_next[wr_addr]  <= w_next;
    if (we_prev)  mem_prev[wr_addr]  <= w_prev;
    rd_start <= mem_start[rd_addr];
    rd_end   <= mem_end[rd_addr];
    rd_next  <= mem_next[rd_addr];
    rd_prev  <= mem_prev[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= '0;
      top   <= '0;
      fe    <= 1'b0;
      limit <= LIMIT_RESET;
    end else begin
      if (cfg_we) limit <= cfg_limit;
      case (cmd)
        CMD_CLEAR: begin
          busy <= '0;
          top  <= '0;
          fe   <= 1'b0;
        end
        CMD_SET_FE: fe <= 1'b1;
        CMD_RSZ_COMMIT: if (!nx_valid && rsz_end > top) top <= rsz_end;
        CMD_FREE_TRIM: begin
          if (top >= rd_end + THR) top <= rd_end;
          busy[cur] <= 1'b0;
        end
        CMD_FREE_LINK2: busy[cur] <= 1'b0;
        CMD_ALLOC_FIRST: begin
          busy <= ONLY0;
          fe   <= 1'b0;
          top  <= sz;
        end
        CMD_REUSE0: begin
          fe  <= 1'b0;
          top <= new_top;
        end
        CMD_NEW_BLOCK: begin
          busy[idx] <= 1'b1;
          top       <= new_top;
        end
        default: ;
      endcase
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LATCH: begin
        op     <= op_t'(in_op);
        size   <= in_size;
        handle <= in_handle;
        idx    <= '0;
        ok     <= 1'b0;
        addr   <= '0;
      end
      CMD_FIND_STEP: begin
        if (st.match) begin
          cur <= idx;
          nx  <= rd_next;
          pv  <= rd_prev;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      CMD_RSZ_COMMIT, CMD_CLEAR, CMD_SET_FE, CMD_FREE_TRIM, CMD_FREE_LINK2: ok <= 1'b1;
      CMD_ALLOC_FIRST, CMD_REUSE0: begin
        ok   <= 1'b1;
        addr <= ADDR_W'(HDR);
      end
      CMD_WALK_INIT: begin
        cur     <= '0;
        cur_end <= rd_end;
        t_end   <= fe ? sz : rd_end + sz;
        nx      <= rd_next;
        n       <= '0;
        new_top <= top;
      end
      CMD_WALK_END: if (t_end > top) new_top <= t_end;
      CMD_WALK_STEP: begin
        cur     <= nx[SW-1:0];
        cur_end <= rd_end;
        t_end   <= rd_end + sz;
        nx      <= rd_next;
        n       <= n + 1'b1;
      end
      CMD_SCAN_INIT: idx <= SW'(1);
      CMD_IDX_INC:   idx <= idx + 1'b1;
      CMD_NEW_BLOCK: begin
        ok   <= 1'b1;
        addr <= ADDR_W'(cur_end + HDR);
      end
      CMD_LOAD_OUT: begin
        out_ok   <= ok;
        out_addr <= addr;
        out_end  <= top[END_W-1:0];
      end
      default: ;
    endcase
  end

endmodule

@@ sv/first_fit_heap_allocator_unit.sv @@
// Top level: first-fit heap allocator with stream ports and a limit register.
// One item at a time. Allocate: walks the list (one table read per block), then scans
// the table for a free slot. Resize and free: search the table for the handle.
// The block table memories are not cleared by reset; busy bits, heap top, the
// emptied-first flag and the limit (1048576) are reset synchronously by rst.
`timescale 1ns / 1ps
module first_fit_heap_allocator_unit #(
  parameter int MAX_BLOCKS        = 64,
  parameter int HEAP_ADDR_BITS    = 20,
  parameter int ALIGN_BITS        = 3,
  parameter int HEADER_BYTES      = 24,
  parameter int RELEASE_THRESHOLD = 32768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // size[20:0], handle[40:21], zero pad
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // address[19:0], heap_end[40:20], zero pad
  output logic [0:0]  m_axis_tuser,   // ok[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [20:0] cfg_data        // heap_limit
);
  import ffha_pkg::*;

  dp_cmd_t           cmd;
  dp_status_t        st;
  logic              out_ok;
  logic [ADDR_W-1:0] out_addr;
  logic [END_W-1:0]  out_end;

  assign cfg_ready = 1'b1;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .st        (st),
    .cmd       (cmd)
  );

  ffha_dp #(
    .MAX_BLOCKS        (MAX_BLOCKS),
    .HEAP_ADDR_BITS    (HEAP_ADDR_BITS),
    .ALIGN_BITS        (ALIGN_BITS),
    .HEADER_BYTES      (HEADER_BYTES),
    .RELEASE_THRESHOLD (RELEASE_THRESHOLD)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_op     (s_axis_tuser),
    .in_size   (s_axis_tdata[20:0]),
    .in_handle (s_axis_tdata[40:21]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_limit (cfg_data),
    .out_ok    (out_ok),
    .out_addr  (out_addr),
    .out_end   (out_end)
  );

  assign m_axis_tdata = {7'b0, out_end, out_addr};
  assign m_axis_tuser = out_ok;

  // a failed item never reports an address
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[19:0] == 20'd0)
    else $error("failed item with nonzero address");

  // after taking an item the unit is busy until its result is formed
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  // a successful allocate never returns an address inside the first header
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] && m_axis_tdata[19:0] != 20'd0 |->
      m_axis_tdata[19:0] >= 20'(HEADER_BYTES))
    else $error("allocated address below header size");

endmodule

@@ tb/ffha_checker.sv @@
// Channel monitor, allocator predictor and result comparison for the heap allocator.
`timescale 1ns / 1ps
module ffha_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [20:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import ffha_pkg::*;

  localparam int NB   = 64;
  localparam int NIL  = 64;
  localparam int HDR  = 24;
  localparam int TRIM = 32768;
  localparam logic [VW-1:0] SPAN = 23'd1048576;

  typedef logic [VW-1:0] ofs_t;

  typedef struct {
    logic              ok;
    logic [ADDR_W-1:0] addr;
    logic [END_W-1:0]  heap_end;
  } outcome_t;

  ofs_t             blk_start [NB];
  ofs_t             blk_end   [NB];
  int               nxt       [NB];
  int               prv       [NB];
  bit               busy      [NB];
  ofs_t             top;
  bit               first_empty;
  logic [LIMIT_W-1:0] limit_reg;
  outcome_t         outcome_q[$];

  function automatic ofs_t cap();
    ofs_t l;
    l = {2'b00, limit_reg};
    return (l < SPAN) ? l : SPAN;
  endfunction

  function automatic bit live(int l);
    return l < NB && busy[l];
  endfunction

  function automatic void wipe();
    for (int i = 0; i < NB; i++) busy[i] = 0;
    top = '0;
    first_empty = 0;
  endfunction

  function automatic int lookup(logic [HANDLE_W-1:0] h);
    if (h < HDR) return -1;
    for (int i = 0; i < NB; i++) begin
      if (!busy[i]) continue;
      if (i == 0 && first_empty) continue;
      if (blk_start[i] + HDR == {3'b000, h}) return i;
    end
    return -1;
  endfunction

  function automatic bit alloc_block(logic [SIZE_W-1:0] size, output ofs_t a);
    ofs_t sz, t_end, new_top, lim;
    int cur, nx, s;
    bit found;
    lim = cap();
    a = '0;
    cur = 0;
    found = 0;
    if (size == 0) return 0;
    sz = ({2'b00, size} + HDR + 7) & ~ofs_t'(7);
    if (!busy[0]) begin
      if (sz > lim) return 0;
      wipe();
      blk_start[0] = '0;
      blk_end[0] = sz;
      nxt[0] = NIL;
      prv[0] = NIL;
      busy[0] = 1;
      top = sz;
      a = HDR;
      return 1;
    end
    t_end = first_empty ? sz : blk_end[0] + sz;
    new_top = top;
    for (int n = 0; n < NB; n++) begin
      nx = nxt[cur];
      if (!live(nx)) begin
        if (t_end > top) begin
          if (t_end > lim) return 0;
          new_top = t_end;
        end
        found = 1;
        break;
      end
      if (blk_start[nx] >= t_end) begin
        found = 1;
        break;
      end
      cur = nx;
      t_end = blk_end[cur] + sz;
    end
    if (!found) return 0;
    if (cur == 0 && first_empty) begin
      blk_end[0] = t_end;
      first_empty = 0;
      top = new_top;
      a = HDR;
      return 1;
    end
    for (s = 1; s < NB; s++)
      if (!busy[s]) break;
    if (s >= NB) return 0;
    nx = nxt[cur];
    blk_start[s] = blk_end[cur];
    blk_end[s] = t_end;
    prv[s] = cur;
    nxt[s] = live(nx) ? nx : NIL;
    if (live(nx)) prv[nx] = s;
    nxt[cur] = s;
    busy[s] = 1;
    top = new_top;
    a = blk_start[s] + HDR;
    return 1;
  endfunction

  function automatic bit resize_block(logic [HANDLE_W-1:0] h, logic [SIZE_W-1:0] size);
    int i, nx;
    ofs_t t_end;
    i = lookup(h);
    if (i < 0) return 0;
    t_end = {3'b000, h} + (({2'b00, size} + 7) & ~ofs_t'(7));
    nx = nxt[i];
    if (!live(nx)) begin
      if (t_end > top) begin
        if (t_end > cap()) return 0;
        top = t_end;
      end
    end else if (blk_start[nx] < t_end) begin
      return 0;
    end
    blk_end[i] = t_end;
    return 1;
  endfunction

  function automatic bit free_block(logic [HANDLE_W-1:0] h);
    int i, nx, pv;
    i = lookup(h);
    if (i < 0) return 0;
    nx = nxt[i];
    pv = prv[i];
    if (i == 0) begin
      if (!live(nx)) wipe();
      else first_empty = 1;
      return 1;
    end
    if (!live(pv)) return 0;
    if (!live(nx)) begin
      if (pv == 0 && first_empty) begin
        wipe();
        return 1;
      end
      if (top >= blk_end[pv] + TRIM) top = blk_end[pv];
      nxt[pv] = NIL;
    end else begin
      nxt[pv] = nx;
      prv[nx] = pv;
    end
    busy[i] = 0;
    return 1;
  endfunction

  function automatic outcome_t run_op(op_t op, logic [SIZE_W-1:0] size,
                                      logic [HANDLE_W-1:0] h);
    outcome_t r;
    ofs_t a;
    bit ok;
    a = '0;
    ok = 0;
    case (op)
      OP_ALLOC:  ok = alloc_block(size, a);
      OP_RESIZE: ok = resize_block(h, size);
      OP_FREE:   ok = free_block(h);
      default:   ok = 0;
    endcase
    r.ok = ok;
    r.addr = ok ? a[ADDR_W-1:0] : '0;
    r.heap_end = top[END_W-1:0];
    return r;
  endfunction

  task automatic report(string msg);
    if (fail_count < 40) $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    outcome_t e;
    logic [ADDR_W-1:0] got_addr;
    logic [END_W-1:0]  got_end;
    if (rst) begin
      wipe();
      limit_reg = LIMIT_RESET;
      outcome_q.delete();
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) limit_reg = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        outcome_q.push_back(run_op(op_t'(s_axis_tuser), s_axis_tdata[20:0],
                                   s_axis_tdata[40:21]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_addr = m_axis_tdata[19:0];
        got_end = m_axis_tdata[40:20];
        if (outcome_q.size() == 0) begin
          report("result item with nothing expected");
        end else begin
          e = outcome_q.pop_front();
          if (m_axis_tuser[0] !== e.ok)
            report($sformatf("ok got %b exp %b", m_axis_tuser[0], e.ok));
          if (got_addr !== e.addr)
            report($sformatf("address got %0d exp %0d", got_addr, e.addr));
          if (got_end !== e.heap_end)
            report($sformatf("heap_end got %0d exp %0d", got_end, e.heap_end));
        end
      end
      pending = outcome_q.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// Stimulus and verdict for the first-fit heap allocator.
`timescale 1ns / 1ps
module tb;
  import ffha_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [20:0] cfg_data;
  int          fail_count;
  int          pending;

  bit                  gaps_on;
  int                  stall_left;
  logic [HANDLE_W-1:0] live_handles[$];

  first_fit_heap_allocator_unit u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  ffha_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 0;
  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  // result side: random stall per item while gaps are on, plus collecting handles of live blocks
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
      stall_left <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (m_axis_tuser[0] && m_axis_tdata[19:0] != 0) begin
          live_handles.push_back(m_axis_tdata[19:0]);
          if (live_handles.size() > 200) void'(live_handles.pop_front());
        end
        stall_left <= gaps_on ? $urandom_range(0, 14) : 0;
        m_axis_tready <= 0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  task automatic send_item(op_t op, logic [SIZE_W-1:0] size, logic [HANDLE_W-1:0] h);
    int gap;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {7'd0, h, size};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [HANDLE_W-1:0] pick_handle(bit take);
    int k;
    logic [HANDLE_W-1:0] h;
    if (live_handles.size() == 0 || $urandom_range(0, 9) == 0) return HANDLE_W'($urandom);
    k = $urandom_range(0, live_handles.size() - 1);
    h = live_handles[k];
    if (take) live_handles.delete(k);
    return h;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 0;
    if (r < 8) return SIZE_W'($urandom);
    if (r < 15) return SIZE_W'($urandom_range(20000, 60000));
    return SIZE_W'($urandom_range(1, 3000));
  endfunction

  task automatic random_items(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (i == n / 2) drain();  // sender holds until every result is back
      if (r < 45) send_item(OP_ALLOC, pick_size(), HANDLE_W'($urandom));
      else if (r < 65) send_item(OP_RESIZE, pick_size(), pick_handle(0));
      else if (r < 97) send_item(OP_FREE, SIZE_W'($urandom), pick_handle(1));
      else send_item(OP_BAD, SIZE_W'($urandom), pick_handle(0));
    end
  endtask

  initial begin
    logic [LIMIT_W-1:0] limits[5];
    limits = '{21'h1FFFFF, 21'd0, 21'd4096, 21'd300000, LIMIT_RESET};
    rst = 1;
    gaps_on = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_ALLOC;
    cfg_valid = 0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: size zero, trim, reuse of emptied first block, clear, limits
    send_item(OP_ALLOC, 0, 0);
    send_item(OP_ALLOC, 1, 0);
    send_item(OP_ALLOC, 100, 0);
    send_item(OP_RESIZE, 8, 0);
    send_item(OP_BAD, 21'h1FFFFF, 20'hFFFFF);
    send_item(OP_ALLOC, 40000, 0);
    send_item(OP_FREE, 0, 184);
    send_item(OP_RESIZE, 0, 56);
    send_item(OP_RESIZE, 200, 56);
    send_item(OP_RESIZE, 21'h1FFFFF, 56);
    send_item(OP_FREE, 0, 24);
    send_item(OP_ALLOC, 8, 0);
    send_item(OP_FREE, 0, 24);
    send_item(OP_RESIZE, 4, 24);
    send_item(OP_FREE, 0, 56);
    send_item(OP_ALLOC, 21'd1048576, 0);
    send_item(OP_ALLOC, 21'd1048552, 0);
    send_item(OP_FREE, 0, 20'hFFFFF);
    send_item(OP_FREE, 0, 24);

    // fill the block table past its size
    for (int i = 0; i < 70; i++) send_item(OP_ALLOC, SIZE_W'($urandom_range(1, 64)), 0);
    for (int i = 0; i < 8; i++) send_item(OP_FREE, 0, pick_handle(1));

    foreach (limits[p]) begin
      write_limit(limits[p]);
      gaps_on = (p % 2 == 0);
      random_items(350);
    end

    s_axis_tvalid <= 0;
    for (int t = 0; t < 200000 && pending != 0; t++) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
